/* src/tot_pkg.sv */
package tot_pkg;

    // Window geometry: the window depth is a power of two so the average is a shift
    localparam int WIN_LOG2  = 3;
    localparam int WIN_DEPTH = 1 << WIN_LOG2;
    localparam int SLOT_W    = (WIN_LOG2 > 0) ? WIN_LOG2 : 1;

    localparam int AXIS_W     = 16;
    localparam int SUM_W      = AXIS_W + WIN_LOG2;
    localparam int THR_W      = 15;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PORTRAIT_TIMEOUT = 1'd1;

    // Configuration reset values
    localparam logic [THR_W-1:0] MOVE_THRESHOLD_RST   = 15'd100;
    localparam logic [CNT_W-1:0] PORTRAIT_TIMEOUT_RST = 16'd600;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // Orientation and face-up limits on the averaged axes
    localparam axis_t LAND_Y_LIM  = 16'sd800;   // portrait -> landscape when |y| beyond this
    localparam axis_t LAND_X_MAX  = 16'sd500;   // ... and x below this
    localparam axis_t PORT_Y_LIM  = 16'sd400;   // landscape -> portrait when |y| within this
    localparam axis_t PORT_X_MIN  = 16'sd500;   // ... and |x| beyond this
    localparam axis_t FACE_XY_LIM = 16'sd50;
    localparam axis_t FACE_Z_MAX  = -16'sd1000;

    typedef struct packed {
        axis_t x;
        axis_t y;
        axis_t z;
    } axes_t;

    typedef struct packed {
        sum_t x;
        sum_t y;
        sum_t z;
    } sums_t;

    // Beat leaving the window stage: running sums after this sample
    typedef struct packed {
        logic  prime;
        logic  tap;
        sums_t sum;
    } sum_beat_t;

    // Beat leaving the averaging stage
    typedef struct packed {
        logic  prime;
        logic  tap;
        axes_t mean;
    } mean_beat_t;

endpackage

/* src/tot_ram.sv */
module tot_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/tot_window.sv */
module tot_window (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  tot_pkg::axes_t     in_sample,
    input  logic               in_tap,
    output logic               out_valid,
    input  logic               out_free,
    output tot_pkg::sum_beat_t out_beat
);

    import tot_pkg::*;

    logic              primed_reg;
    logic              wrapped_reg;
    logic [SLOT_W-1:0] slot_reg;
    axes_t             prime_reg;

    logic              s1_valid_reg;
    logic              s1_prime_reg;
    logic              s1_fresh_reg;
    logic              s1_fwd_reg;
    logic              s1_tap_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    axes_t             s1_sample_reg;
    axes_t             s1_fwd_data_reg;

    logic              o_valid_reg;
    sum_beat_t         o_beat_reg;

    logic              accept;
    logic              advance;
    logic              ram_we;
    logic [47:0]       ram_rdata;
    axes_t             old_sample;
    sums_t             sum_next;

    assign in_ready = !s1_valid_reg || out_free;
    assign accept   = in_valid && in_ready;
    assign advance  = s1_valid_reg && out_free;
    assign ram_we   = advance && !s1_prime_reg;

    tot_ram #(
        .WIDTH ($bits(axes_t)),
        .DEPTH (WIN_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_slot_reg),
        .wdata (s1_sample_reg),
        .re    (accept),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Slot pointer, priming sample and wrap flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg  <= 1'b0;
            wrapped_reg <= 1'b0;
            slot_reg    <= '0;
        end else if (accept) begin
            if (!primed_reg) begin
                primed_reg <= 1'b1;
            end else if (slot_reg == SLOT_W'(WIN_DEPTH - 1)) begin
                slot_reg    <= '0;
                wrapped_reg <= 1'b1;
            end else begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !primed_reg) begin
            prime_reg <= in_sample;
        end
    end

    // Read stage: hold the beat while the RAM word comes back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_prime_reg    <= !primed_reg;
            s1_fresh_reg    <= !wrapped_reg;
            s1_fwd_reg      <= ram_we && (s1_slot_reg == slot_reg);
            s1_fwd_data_reg <= s1_sample_reg;
            s1_tap_reg      <= in_tap;
            s1_slot_reg     <= slot_reg;
            s1_sample_reg   <= in_sample;
        end
    end

    // Slots not written since priming still hold the priming sample
    always_comb begin
        if (s1_fwd_reg) begin
            old_sample = s1_fwd_data_reg;
        end else if (s1_fresh_reg) begin
            old_sample = prime_reg;
        end else begin
            old_sample = axes_t'(ram_rdata);
        end
    end

    // Running sums: replace the oldest sample, or fill from the priming sample
    always_comb begin
        if (s1_prime_reg) begin
            sum_next.x = sum_t'(s1_sample_reg.x) <<< WIN_LOG2;
            sum_next.y = sum_t'(s1_sample_reg.y) <<< WIN_LOG2;
            sum_next.z = sum_t'(s1_sample_reg.z) <<< WIN_LOG2;
        end else begin
            sum_next.x = o_beat_reg.sum.x + sum_t'(s1_sample_reg.x) - sum_t'(old_sample.x);
            sum_next.y = o_beat_reg.sum.y + sum_t'(s1_sample_reg.y) - sum_t'(old_sample.y);
            sum_next.z = o_beat_reg.sum.z + sum_t'(s1_sample_reg.z) - sum_t'(old_sample.z);
        end
    end

    // Sum stage: the held sums are the running sums of the window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (out_free) begin
            o_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            o_beat_reg.prime <= s1_prime_reg;
            o_beat_reg.tap   <= s1_tap_reg;
            o_beat_reg.sum   <= sum_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_beat  = o_beat_reg;

endmodule

/* src/tot_average.sv */
module tot_average (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_free,
    input  tot_pkg::sum_beat_t  in_beat,
    output logic                out_valid,
    input  logic                out_free,
    output tot_pkg::mean_beat_t out_beat
);

    import tot_pkg::*;

    logic       valid_reg;
    mean_beat_t beat_reg;
    axes_t      mean;

    function automatic axis_t avg(input sum_t s);
        sum_t bias;
        sum_t q;
        begin
            // Bias negative sums so the shift truncates toward zero
            bias = s[SUM_W-1] ? sum_t'(WIN_DEPTH - 1) : '0;
            q    = (s + bias) >>> WIN_LOG2;
            return q[AXIS_W-1:0];
        end
    endfunction

    assign mean.x = avg(in_beat.sum.x);
    assign mean.y = avg(in_beat.sum.y);
    assign mean.z = avg(in_beat.sum.z);

    assign in_free = !valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_free) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_free && in_valid) begin
            beat_reg.prime <= in_beat.prime;
            beat_reg.tap   <= in_beat.tap;
            beat_reg.mean  <= mean;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

/* src/tot_decide.sv */
module tot_decide (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_free,
    input  tot_pkg::mean_beat_t        in_beat,
    input  logic [tot_pkg::THR_W-1:0]  move_threshold,
    input  logic [tot_pkg::CNT_W-1:0]  portrait_timeout,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_orientation,
    output logic                       m_orientation_changed,
    output logic                       m_picked_up,
    output logic                       m_double_tap,
    output logic                       m_lay_flat_prompt,
    output logic signed [15:0]         m_mean_x,
    output logic signed [15:0]         m_mean_y,
    output logic signed [15:0]         m_mean_z
);

    import tot_pkg::*;

    logic             m_valid_reg;
    logic             orient_out_reg;
    logic             changed_out_reg;
    logic             picked_out_reg;
    logic             tap_out_reg;
    logic             prompt_out_reg;
    axes_t            mean_out_reg;

    logic             is_portrait_reg;
    logic             prompt_fired_reg;
    logic             running_reg;
    logic [CNT_W-1:0] countdown_reg;
    axes_t            prev_mean_reg;

    logic             is_portrait_next;
    logic             prompt_fired_next;
    logic             running_next;
    logic [CNT_W-1:0] countdown_next;
    logic             changed;
    logic             picked;
    logic             prompt;
    logic             face_up;
    logic             moved;
    logic             load;
    axis_t            mx;
    axis_t            my;
    axis_t            mz;

    function automatic logic beyond(input axis_t a, input axis_t b,
                                    input logic [THR_W-1:0] thr);
        logic signed [AXIS_W:0] d;
        logic [AXIS_W:0]        m;
        begin
            d = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
            m = d[AXIS_W] ? (~d + 1'b1) : d;
            return m > (AXIS_W + 1)'(thr);
        end
    endfunction

    assign mx = in_beat.mean.x;
    assign my = in_beat.mean.y;
    assign mz = in_beat.mean.z;

    assign face_up = (mx > -FACE_XY_LIM) && (mx < FACE_XY_LIM) &&
                     (my > -FACE_XY_LIM) && (my < FACE_XY_LIM) && (mz < FACE_Z_MAX);

    assign moved = beyond(mx, prev_mean_reg.x, move_threshold) ||
                   beyond(my, prev_mean_reg.y, move_threshold) ||
                   beyond(mz, prev_mean_reg.z, move_threshold);

    assign in_free = !m_valid_reg || m_ready;
    assign load    = in_valid && in_free;

    // Orientation hysteresis, pick-up and portrait timer
    always_comb begin
        is_portrait_next  = is_portrait_reg;
        prompt_fired_next = prompt_fired_reg;
        running_next      = running_reg;
        countdown_next    = countdown_reg;
        changed           = 1'b0;
        picked            = 1'b0;
        prompt            = 1'b0;
        if (!in_beat.prime) begin
            if (is_portrait_reg) begin
                if (((my < -LAND_Y_LIM) || (my > LAND_Y_LIM)) && (mx < LAND_X_MAX)) begin
                    is_portrait_next = 1'b0;
                    changed          = 1'b1;
                end
            end else begin
                if ((my > -PORT_Y_LIM) && (my < PORT_Y_LIM) &&
                    ((mx > PORT_X_MIN) || (mx < -PORT_X_MIN))) begin
                    is_portrait_next = 1'b1;
                    changed          = 1'b1;
                end
            end

            if (moved) begin
                picked = 1'b1;
                if (prompt_fired_reg) begin
                    prompt_fired_next = 1'b0;
                end else begin
                    running_next = 1'b0;
                end
            end

            if (running_next) begin
                if (countdown_next != '0) begin
                    countdown_next = countdown_next - 1'b1;
                end
                if (countdown_next == '0) begin
                    running_next = 1'b0;
                    if (!face_up) begin
                        prompt_fired_next = 1'b1;
                        prompt            = 1'b1;
                    end
                end
            end

            if (is_portrait_next && !running_next && !prompt_fired_next && !face_up) begin
                running_next   = 1'b1;
                countdown_next = (portrait_timeout == '0) ? CNT_W'(1) : portrait_timeout;
            end
        end
    end

    // Tracker state advances once per beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is_portrait_reg  <= 1'b0;
            prompt_fired_reg <= 1'b0;
            running_reg      <= 1'b0;
            countdown_reg    <= '0;
        end else if (load) begin
            is_portrait_reg  <= is_portrait_next;
            prompt_fired_reg <= prompt_fired_next;
            running_reg      <= running_next;
            countdown_reg    <= countdown_next;
        end
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_free) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prev_mean_reg   <= in_beat.mean;
            orient_out_reg  <= is_portrait_next;
            changed_out_reg <= changed;
            picked_out_reg  <= picked;
            tap_out_reg     <= in_beat.tap;
            prompt_out_reg  <= prompt;
            mean_out_reg    <= in_beat.mean;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_orientation         = orient_out_reg;
    assign m_orientation_changed = changed_out_reg;
    assign m_picked_up           = picked_out_reg;
    assign m_double_tap          = tap_out_reg;
    assign m_lay_flat_prompt     = prompt_out_reg;
    assign m_mean_x              = mean_out_reg.x;
    assign m_mean_y              = mean_out_reg.y;
    assign m_mean_z              = mean_out_reg.z;

endmodule

/* src/tilt_orientation_tracker.sv */
// Tilt orientation tracker.
// Input channel (s_*): one accelerometer sample (x, y, z, two's complement) and a
// double-tap flag per beat. Result channel (m_*): one beat per sample with the
// window averages, landscape/portrait state, orientation change, pick-up, the
// forwarded tap and the lay-flat prompt.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0: move
// threshold, 1: portrait timeout in samples); write only while the block is idle.
// Each sample passes the registered window read, running sum and average stages,
// then the decision into the output register.
// Throughput: one sample per cycle while the receiver does not stall; the window
// RAM is read for the next sample while the previous sample writes its slot back.
// The first sample after reset primes the window: its result carries the sample
// as the averages. Reset empties the pipeline, restores landscape, stops the
// portrait timer and loads register defaults (threshold 100, timeout 600).
// When the receiver stalls the output beat holds and bubbles inside the pipeline
// still fill, so up to three more samples are taken before s_ready drops.
module tilt_orientation_tracker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [15:0]               s_sample_x,
    input  logic signed [15:0]               s_sample_y,
    input  logic signed [15:0]               s_sample_z,
    input  logic                             s_tap_seen,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_orientation,
    output logic                             m_orientation_changed,
    output logic                             m_picked_up,
    output logic                             m_double_tap,
    output logic                             m_lay_flat_prompt,
    output logic signed [15:0]               m_mean_x,
    output logic signed [15:0]               m_mean_y,
    output logic signed [15:0]               m_mean_z,
    input  logic                             cfg_we,
    input  logic [tot_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tot_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import tot_pkg::*;

    logic [THR_W-1:0] move_threshold_reg;
    logic [CNT_W-1:0] portrait_timeout_reg;

    axes_t            in_sample;
    logic             win_valid;
    logic             avg_free;
    sum_beat_t        win_beat;
    logic             avg_valid;
    logic             dec_free;
    mean_beat_t       avg_beat;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_threshold_reg   <= MOVE_THRESHOLD_RST;
            portrait_timeout_reg <= PORTRAIT_TIMEOUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MOVE_THRESHOLD:   move_threshold_reg   <= cfg_wdata[THR_W-1:0];
                REG_PORTRAIT_TIMEOUT: portrait_timeout_reg <= cfg_wdata[CNT_W-1:0];
            endcase
        end
    end

    assign in_sample.x = s_sample_x;
    assign in_sample.y = s_sample_y;
    assign in_sample.z = s_sample_z;

    tot_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_sample (in_sample),
        .in_tap    (s_tap_seen),
        .out_valid (win_valid),
        .out_free  (avg_free),
        .out_beat  (win_beat)
    );

    tot_average u_average (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (win_valid),
        .in_free   (avg_free),
        .in_beat   (win_beat),
        .out_valid (avg_valid),
        .out_free  (dec_free),
        .out_beat  (avg_beat)
    );

    tot_decide u_decide (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .in_valid              (avg_valid),
        .in_free               (dec_free),
        .in_beat               (avg_beat),
        .move_threshold        (move_threshold_reg),
        .portrait_timeout      (portrait_timeout_reg),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_orientation         (m_orientation),
        .m_orientation_changed (m_orientation_changed),
        .m_picked_up           (m_picked_up),
        .m_double_tap          (m_double_tap),
        .m_lay_flat_prompt     (m_lay_flat_prompt),
        .m_mean_x              (m_mean_x),
        .m_mean_y              (m_mean_y),
        .m_mean_z              (m_mean_z)
    );

endmodule

/* src/tot_checker.sv */
module tot_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_orientation,
    input logic               m_orientation_changed,
    input logic               m_picked_up,
    input logic               m_double_tap,
    input logic               m_lay_flat_prompt,
    input logic signed [15:0] m_mean_x,
    input logic signed [15:0] m_mean_y,
    input logic signed [15:0] m_mean_z
);

    logic seen_reg;
    logic last_orient_reg;
    logic m_beat;

    assign m_beat = m_valid && m_ready;

    // Track the orientation of the last delivered beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg        <= 1'b0;
            last_orient_reg <= 1'b0;
        end else if (m_beat) begin
            seen_reg        <= 1'b1;
            last_orient_reg <= m_orientation;
        end
    end

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_orientation) &&
            $stable(m_orientation_changed) && $stable(m_picked_up) &&
            $stable(m_double_tap) && $stable(m_lay_flat_prompt) &&
            $stable(m_mean_x) && $stable(m_mean_y) && $stable(m_mean_z))
        else $error("stalled result beat changed");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with the output register empty");

    a_change_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && seen_reg |-> (m_orientation != last_orient_reg) == m_orientation_changed)
        else $error("orientation change flag disagrees with delivered orientation");

endmodule

bind tilt_orientation_tracker tot_checker u_tot_checker (
    .aclk                  (aclk),
    .aresetn               (aresetn),
    .s_ready               (s_ready),
    .m_valid               (m_valid),
    .m_ready               (m_ready),
    .m_orientation         (m_orientation),
    .m_orientation_changed (m_orientation_changed),
    .m_picked_up           (m_picked_up),
    .m_double_tap          (m_double_tap),
    .m_lay_flat_prompt     (m_lay_flat_prompt),
    .m_mean_x              (m_mean_x),
    .m_mean_y              (m_mean_y),
    .m_mean_z              (m_mean_z)
);

/* tb/tilt_orientation_checker.sv */
`timescale 1ns / 1ps

module tilt_orientation_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  tot_pkg::axis_t                 s_sample_x,
    input  tot_pkg::axis_t                 s_sample_y,
    input  tot_pkg::axis_t                 s_sample_z,
    input  logic                           s_tap_seen,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_orientation,
    input  logic                           m_orientation_changed,
    input  logic                           m_picked_up,
    input  logic                           m_double_tap,
    input  logic                           m_lay_flat_prompt,
    input  tot_pkg::axis_t                 m_mean_x,
    input  tot_pkg::axis_t                 m_mean_y,
    input  tot_pkg::axis_t                 m_mean_z,
    input  logic                           cfg_we,
    input  logic [tot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tot_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             expected_left
);
    import tot_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic  orientation;
        logic  changed;
        logic  picked;
        logic  tap;
        logic  prompt;
        axis_t mean_x;
        axis_t mean_y;
        axis_t mean_z;
    } tilt_result_t;

    // Shadow of the tracker state
    int  hist_x [WIN_DEPTH];
    int  hist_y [WIN_DEPTH];
    int  hist_z [WIN_DEPTH];
    int  run_x, run_y, run_z;
    int  next_slot;
    int  last_x, last_y, last_z;
    bit  portrait_now;
    bit  prompt_latched;
    bit  timer_on;
    int  timer_left;
    bit  seeded;
    int  move_limit;
    int  portrait_limit;

    tilt_result_t expected_beats [$];
    int           mismatches = 0;

    function automatic int mag_of(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit lying_face_up(input int mx, input int my, input int mz);
        return mag_of(mx) < FACE_XY_LIM && mag_of(my) < FACE_XY_LIM && mz < FACE_Z_MAX;
    endfunction

    // Advance the shadow state by one sample and return the beat it should produce
    function automatic tilt_result_t predict_tilt(input axis_t sx, input axis_t sy,
                                                  input axis_t sz, input logic tap);
        tilt_result_t r;
        int           mx, my, mz;
        int           slot;
        bit           flat;
        r = '0;
        r.tap = tap;
        if (!seeded) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
                hist_x[k] = sx;
                hist_y[k] = sy;
                hist_z[k] = sz;
            end
            run_x     = sx * WIN_DEPTH;
            run_y     = sy * WIN_DEPTH;
            run_z     = sz * WIN_DEPTH;
            next_slot = 0;
            last_x    = sx;
            last_y    = sy;
            last_z    = sz;
            seeded    = 1'b1;
            mx        = sx;
            my        = sy;
            mz        = sz;
        end else begin
            // Replace the oldest slot and average, truncating toward zero
            slot         = next_slot;
            run_x        = run_x + sx - hist_x[slot];
            run_y        = run_y + sy - hist_y[slot];
            run_z        = run_z + sz - hist_z[slot];
            hist_x[slot] = sx;
            hist_y[slot] = sy;
            hist_z[slot] = sz;
            next_slot    = (slot + 1) % WIN_DEPTH;
            mx           = run_x / WIN_DEPTH;
            my           = run_y / WIN_DEPTH;
            mz           = run_z / WIN_DEPTH;
            flat         = lying_face_up(mx, my, mz);

            // Orientation with hysteresis
            if (portrait_now) begin
                if ((my < -LAND_Y_LIM || my > LAND_Y_LIM) && mx < LAND_X_MAX) begin
                    portrait_now = 1'b0;
                    r.changed    = 1'b1;
                end
            end else if (my > -PORT_Y_LIM && my < PORT_Y_LIM &&
                         (mx > PORT_X_MIN || mx < -PORT_X_MIN)) begin
                portrait_now = 1'b1;
                r.changed    = 1'b1;
            end

            // Pick-up clears a fired prompt, otherwise stops the timer
            if (mag_of(mx - last_x) > move_limit || mag_of(my - last_y) > move_limit ||
                mag_of(mz - last_z) > move_limit) begin
                r.picked = 1'b1;
                if (prompt_latched)
                    prompt_latched = 1'b0;
                else
                    timer_on = 1'b0;
            end
            last_x = mx;
            last_y = my;
            last_z = mz;

            // Count down; the timer may expire after leaving portrait
            if (timer_on) begin
                if (timer_left > 0)
                    timer_left--;
                if (timer_left == 0) begin
                    timer_on = 1'b0;
                    if (!flat) begin
                        prompt_latched = 1'b1;
                        r.prompt       = 1'b1;
                    end
                end
            end

            if (portrait_now && !timer_on && !prompt_latched && !flat) begin
                timer_on   = 1'b1;
                timer_left = (portrait_limit == 0) ? 1 : portrait_limit;
            end
        end
        r.orientation = portrait_now;
        r.mean_x      = axis_t'(mx);
        r.mean_y      = axis_t'(my);
        r.mean_z      = axis_t'(mz);
        return r;
    endfunction

    task automatic flag_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Track config writes, check result beats, predict accepted samples
    always @(posedge aclk) begin : track_beats
        tilt_result_t want;
        if (!aresetn) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
                hist_x[k] = 0;
                hist_y[k] = 0;
                hist_z[k] = 0;
            end
            run_x          = 0;
            run_y          = 0;
            run_z          = 0;
            next_slot      = 0;
            last_x         = 0;
            last_y         = 0;
            last_z         = 0;
            portrait_now   = 1'b0;
            prompt_latched = 1'b0;
            timer_on       = 1'b0;
            timer_left     = 0;
            seeded         = 1'b0;
            move_limit     = int'(MOVE_THRESHOLD_RST);
            portrait_limit = int'(PORTRAIT_TIMEOUT_RST);
            expected_beats.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MOVE_THRESHOLD: begin
                        move_limit = int'(cfg_wdata[THR_W-1:0]);
                    end
                    REG_PORTRAIT_TIMEOUT: begin
                        portrait_limit = int'(cfg_wdata[CNT_W-1:0]);
                    end
                    default: begin
                    end
                endcase
            end

            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result beat: nothing predicted");
                end else begin
                    want = expected_beats.pop_front();
                    flag_field("orientation", want.orientation, m_orientation);
                    flag_field("orientation_changed", want.changed, m_orientation_changed);
                    flag_field("picked_up", want.picked, m_picked_up);
                    flag_field("double_tap", want.tap, m_double_tap);
                    flag_field("lay_flat_prompt", want.prompt, m_lay_flat_prompt);
                    flag_field("mean_x", want.mean_x, m_mean_x);
                    flag_field("mean_y", want.mean_y, m_mean_y);
                    flag_field("mean_z", want.mean_z, m_mean_z);
                end
            end

            if (s_valid && s_ready)
                expected_beats.push_back(predict_tilt(s_sample_x, s_sample_y, s_sample_z,
                                                      s_tap_seen));
        end
        fail_count    <= mismatches;
        expected_left <= expected_beats.size();
    end

endmodule

/* tb/tb_tilt_orientation_tracker.sv */
`timescale 1ns / 1ps

module tb_tilt_orientation_tracker;
    import tot_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 205;
    localparam int DRAIN_CYCLES = 8;
    localparam int AXIS_MAX     = 32767;
    localparam int AXIS_MIN     = -32768;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_t;
    typedef enum int {POSE_LANDSCAPE, POSE_PORTRAIT, POSE_FACE_UP, POSE_EDGE, POSE_RAW} pose_t;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    axis_t                 s_sample_x = '0;
    axis_t                 s_sample_y = '0;
    axis_t                 s_sample_z = '0;
    logic                  s_tap_seen = 1'b0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic                  m_orientation;
    logic                  m_orientation_changed;
    logic                  m_picked_up;
    logic                  m_double_tap;
    logic                  m_lay_flat_prompt;
    axis_t                 m_mean_x;
    axis_t                 m_mean_y;
    axis_t                 m_mean_z;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

    int fail_count;
    int expected_left;
    bit hold_req   = 1'b0;
    int burst_left = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    tilt_orientation_tracker i_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_sample_x            (s_sample_x),
        .s_sample_y            (s_sample_y),
        .s_sample_z            (s_sample_z),
        .s_tap_seen            (s_tap_seen),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_orientation         (m_orientation),
        .m_orientation_changed (m_orientation_changed),
        .m_picked_up           (m_picked_up),
        .m_double_tap          (m_double_tap),
        .m_lay_flat_prompt     (m_lay_flat_prompt),
        .m_mean_x              (m_mean_x),
        .m_mean_y              (m_mean_y),
        .m_mean_z              (m_mean_z),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata)
    );

    tilt_orientation_checker i_checker (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_sample_x            (s_sample_x),
        .s_sample_y            (s_sample_y),
        .s_sample_z            (s_sample_z),
        .s_tap_seen            (s_tap_seen),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_orientation         (m_orientation),
        .m_orientation_changed (m_orientation_changed),
        .m_picked_up           (m_picked_up),
        .m_double_tap          (m_double_tap),
        .m_lay_flat_prompt     (m_lay_flat_prompt),
        .m_mean_x              (m_mean_x),
        .m_mean_y              (m_mean_y),
        .m_mean_z              (m_mean_z),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .fail_count            (fail_count),
        .expected_left         (expected_left)
    );

    function automatic axis_t clamp_axis(input int v);
        if (v > AXIS_MAX)
            return axis_t'(AXIS_MAX);
        if (v < AXIS_MIN)
            return axis_t'(AXIS_MIN);
        return axis_t'(v);
    endfunction

    function automatic int signed_pick(input int mag);
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    // Offer one sample; the sender works in bursts separated by idle gaps
    task automatic offer_sample(input int x, input int y, input int z, input logic tap);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_sample_x <= clamp_axis(x);
        s_sample_y <= clamp_axis(y);
        s_sample_z <= clamp_axis(z);
        s_tap_seen <= tap;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and wait until every predicted beat has come back
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_left != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(data);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Hold a pose for a run of samples with noise, so the averages settle and
    // orientation, pick-up and timer paths are exercised
    task automatic run_poses(input int n_items);
        pose_t pose;
        int    cx, cy, cz, noise, run_left;
        run_left = 0;
        pose     = POSE_RAW;
        cx       = 0;
        cy       = 0;
        cz       = 0;
        noise    = 0;
        for (int i = 0; i < n_items; i++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(4, 40);
                noise    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 600)
                                                       : $urandom_range(0, 40);
                case ($urandom_range(0, 9))
                    0, 1, 2: pose = POSE_LANDSCAPE;
                    3, 4, 5: pose = POSE_PORTRAIT;
                    6, 7:    pose = POSE_FACE_UP;
                    8:       pose = POSE_EDGE;
                    default: pose = POSE_RAW;
                endcase
                case (pose)
                    POSE_LANDSCAPE: begin
                        cx = signed_pick($urandom_range(0, 300));
                        cy = signed_pick($urandom_range(900, 2000));
                        cz = signed_pick($urandom_range(0, 500));
                    end
                    POSE_PORTRAIT: begin
                        cx = signed_pick($urandom_range(600, 2000));
                        cy = signed_pick($urandom_range(0, 300));
                        cz = signed_pick($urandom_range(0, 500));
                    end
                    POSE_FACE_UP: begin
                        cx = signed_pick($urandom_range(0, 30));
                        cy = signed_pick($urandom_range(0, 30));
                        cz = -$urandom_range(1100, 2000);
                    end
                    POSE_EDGE: begin
                        noise = 0;
                        cx = signed_pick(($urandom_range(0, 1) ? FACE_XY_LIM : PORT_X_MIN)
                                         + $urandom_range(0, 10) - 5);
                        case ($urandom_range(0, 2))
                            0:       cy = signed_pick(FACE_XY_LIM + $urandom_range(0, 10) - 5);
                            1:       cy = signed_pick(PORT_Y_LIM + $urandom_range(0, 10) - 5);
                            default: cy = signed_pick(LAND_Y_LIM + $urandom_range(0, 10) - 5);
                        endcase
                        cz = int'(FACE_Z_MAX) + int'($urandom_range(0, 10)) - 5;
                    end
                    default: begin
                    end
                endcase
            end
            run_left--;
            if (pose == POSE_RAW)
                offer_sample($urandom_range(0, 65535) + AXIS_MIN,
                             $urandom_range(0, 65535) + AXIS_MIN,
                             $urandom_range(0, 65535) + AXIS_MIN, $urandom_range(0, 1));
            else
                offer_sample(cx + $urandom_range(0, 2 * noise) - noise,
                             cy + $urandom_range(0, 2 * noise) - noise,
                             cz + $urandom_range(0, 2 * noise) - noise, $urandom_range(0, 1));
        end
    endtask

    // Result side stall pattern, with one long hold-off on request
    initial begin : drive_ready
        rx_mode_t mode;
        int       seg_left;
        int       hold_left;
        bit       hold_done;
        mode      = RX_OPEN;
        seg_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready  <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = rx_mode_t'($urandom_range(0, 2));
                    seg_left = $urandom_range(10, 80);
                end
                seg_left--;
                case (mode)
                    RX_OPEN:  m_ready <= 1'b1;
                    RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
                    default:  m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // End the run if no beat moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (aresetn);
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tilt_orientation_tracker regression: fail");
        $finish;
    end

    initial begin : run_regression
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Priming sample at the extremes, then full-scale swings at reset config
        offer_sample(AXIS_MIN, AXIS_MAX, AXIS_MIN, 1'b1);
        offer_sample(AXIS_MAX, AXIS_MIN, AXIS_MAX, 1'b0);
        offer_sample(0, 0, 0, 1'b1);
        offer_sample(-1, -1, -1, 1'b0);
        offer_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX, 1'b1);
        settle();

        // Threshold with the spare top bit set, zero timeout acting as one sample
        write_reg(REG_MOVE_THRESHOLD, 16'hFFFF);
        write_reg(REG_PORTRAIT_TIMEOUT, 0);
        for (int i = 0; i < 8; i++)
            offer_sample(4000, -1, 100, i % 2);
        for (int i = 0; i < 4; i++)
            offer_sample(0, 0, -3000, 1'b0);
        for (int i = 0; i < 6; i++)
            offer_sample(200, 3000, 0, i % 2);

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: begin
                    write_reg(REG_MOVE_THRESHOLD, 0);
                    write_reg(REG_PORTRAIT_TIMEOUT, 0);
                end
                1: begin
                    write_reg(REG_MOVE_THRESHOLD, MOVE_THRESHOLD_RST);
                    write_reg(REG_PORTRAIT_TIMEOUT, PORTRAIT_TIMEOUT_RST);
                end
                2: begin
                    write_reg(REG_MOVE_THRESHOLD, 16'h7FFF);
                    write_reg(REG_PORTRAIT_TIMEOUT, 16'hFFFF);
                    hold_req = 1'b1;
                end
                3: begin
                    write_reg(REG_MOVE_THRESHOLD, 30);
                    write_reg(REG_PORTRAIT_TIMEOUT, 1);
                end
                default: begin
                    write_reg(REG_MOVE_THRESHOLD,
                              $urandom_range(0, 400) + ($urandom_range(0, 1) ? 32768 : 0));
                    write_reg(REG_PORTRAIT_TIMEOUT, $urandom_range(1, 40));
                end
            endcase
            run_poses(PHASE_ITEMS);
        end
        settle();

        if (fail_count == 0)
            $display("tilt_orientation_tracker regression: pass");
        else
            $display("tilt_orientation_tracker regression: fail");
        $finish;
    end

endmodule
